/* rtl/cprb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cprb_pkg
// Shared codes, types and the CRC-32 byte step for the packet ring buffer.
// ----------------------------------------------------------------------------
package cprb_pkg;

  // request commands
  localparam logic [1:0] CMD_RX    = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_PEEK  = 2'd2;
  localparam logic [1:0] CMD_FLUSH = 2'd3;

  // read status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_TIMEOUT = 2'd1;
  localparam logic [1:0] STAT_CRC     = 2'd2;
  localparam logic [1:0] STAT_EMPTY   = 2'd3;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [5:0]  POS_MAX  = 6'd63;

  // read job handed from the front to the back
  typedef struct packed {
    logic       need_read;
    logic [1:0] status;
    logic [3:0] fill;
  } cprb_job_t;

  // one result entry
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
    logic [3:0] fill;
  } cprb_res_t;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* rtl/cprb_jobq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cprb_jobq
// Two-entry queue of read jobs between the front and the back. Reports
// whether any queued job still reads a given buffer.
// ----------------------------------------------------------------------------
module cprb_jobq import cprb_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         enq,
  input  wire cprb_job_t                    enq_job,
  input  wire logic [$clog2(SLOTS+1)-1:0]   enq_buf,
  output logic                              full,
  input  wire logic                         deq,
  output logic                              empty,
  output cprb_job_t                         head_job,
  output logic [$clog2(SLOTS+1)-1:0]        head_buf,
  input  wire logic [$clog2(SLOTS+1)-1:0]   query_buf,
  output logic                              hit
);

  localparam int BUF_W = $clog2(SLOTS + 1);

  cprb_job_t        job_r [2];
  logic [BUF_W-1:0] buf_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r, cnt_nxt;
  logic [1:0]       valid;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign head_job = job_r[rp_r];
  assign head_buf = buf_r[rp_r];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      valid[i] = (cnt_r == 2'd2) || ((cnt_r == 2'd1) && (rp_r == 1'(i)));
    end
    hit = 1'b0;
    for (int i = 0; i < 2; i++) begin
      if (valid[i] && job_r[i].need_read && (buf_r[i] == query_buf)) begin
        hit = 1'b1;
      end
    end
    cnt_nxt = cnt_r + {1'b0, enq} - {1'b0, deq};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (enq) begin
        wp_r <= ~wp_r;
      end
      if (deq) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      job_r[wp_r] <= enq_job;
      buf_r[wp_r] <= enq_buf;
    end
  end

endmodule
`default_nettype wire

/* rtl/cprb_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cprb_front
// Takes requests, assembles received frames and checks their CRC, keeps the
// ring pointers and fill count, and classifies pop and peek into read jobs.
// ----------------------------------------------------------------------------
module cprb_front import cprb_pkg::*; #(
  parameter int SLOTS      = 8,
  parameter int DATA_BYTES = 32
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire logic                                          in_push,
  output logic                                               in_full,
  input  wire logic [1:0]                                    in_cmd,
  input  wire logic [7:0]                                    in_rx_byte,
  input  wire logic                                          in_rx_last,
  input  wire logic [31:0]                                   in_now_ms,
  input  wire logic                                          cfg_valid,
  output logic                                               cfg_ready,
  input  wire logic [31:0]                                   cfg_wdata,
  input  wire logic                                          jq_full,
  output logic                                               jq_enq,
  output cprb_job_t                                          jq_job,
  output logic [$clog2(SLOTS+1)-1:0]                         jq_buf,
  input  wire logic                                          conflict,
  output logic [$clog2(SLOTS+1)-1:0]                         wr_buf,
  output logic                                               mem_we,
  output logic [$clog2((SLOTS+1)*DATA_BYTES)-1:0]            mem_waddr,
  output logic [7:0]                                         mem_wdata,
  output logic                                               flag_we,
  output logic [$clog2(SLOTS+1)-1:0]                         flag_waddr,
  output logic                                               flag_wdata
);

  localparam int NBUF        = SLOTS + 1;
  localparam int BUF_W       = $clog2(NBUF);
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int ADDR_W      = $clog2(NBUF * DATA_BYTES);
  localparam int FRAME_BYTES = DATA_BYTES + 4;

  // request register
  logic              item_v_r, item_v_nxt;
  logic [1:0]        cmd_r;
  logic [7:0]        byte_r;
  logic              last_r;
  logic [31:0]       now_r;

  logic [31:0]       tmo_r;
  logic [31:0]       crc_r, crc_nxt;
  logic [5:0]        pos_r, pos_nxt;
  logic              ovr_r, ovr_nxt;
  logic [31:0]       rcrc_r, rcrc_nxt;
  logic [BUF_W-1:0]  wr_r, wr_nxt;
  logic [BUF_W-1:0]  rd_r, rd_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [31:0]       last_rx_r, last_rx_nxt;

  logic              proceed, is_rd, rx, timed_out, frame_ok;
  logic              in_data, in_crc;
  logic [6:0]        pos7;
  logic [5:0]        lane_pos;
  logic [31:0]       elapsed, crc_new, rcrc_new;
  logic [BUF_W-1:0]  wr_inc, rd_inc, wr_dec;
  logic [CNT_W-1:0]  fill_cnt;
  logic [CNT_W+3:0]  fill_ext;

  assign cfg_ready = 1'b1;
  assign wr_buf    = wr_r;

  assign elapsed   = now_r - last_rx_r;
  assign timed_out = elapsed > tmo_r;
  assign is_rd     = (cmd_r == CMD_POP) || (cmd_r == CMD_PEEK);

  always_comb begin
    proceed = 1'b0;
    if (item_v_r) begin
      case (cmd_r)
        CMD_RX:   proceed = !conflict;
        CMD_POP:  proceed = !jq_full;
        CMD_PEEK: proceed = !jq_full;
        default:  proceed = 1'b1;
      endcase
    end
  end

  assign in_full    = item_v_r && !proceed;
  assign item_v_nxt = (in_push && !in_full) || in_full;
  assign rx         = proceed && (cmd_r == CMD_RX);

  assign pos7     = {1'b0, pos_r};
  assign in_data  = pos7 < 7'(DATA_BYTES);
  assign in_crc   = !in_data && (pos7 < 7'(FRAME_BYTES));
  assign lane_pos = pos_r - 6'(DATA_BYTES);
  assign crc_new  = (!ovr_r && in_data) ? crc_byte(crc_r, byte_r) : crc_r;
  assign rcrc_new = (!ovr_r && in_crc) ?
                    (rcrc_r | ({24'h0, byte_r} << {lane_pos[1:0], 3'b000})) : rcrc_r;
  assign frame_ok = !ovr_r && ((pos7 + 7'd1) == 7'(FRAME_BYTES));

  assign wr_inc = (wr_r == BUF_W'(NBUF - 1)) ? '0 : wr_r + 1'b1;
  assign rd_inc = (rd_r == BUF_W'(NBUF - 1)) ? '0 : rd_r + 1'b1;
  assign wr_dec = (wr_r == '0) ? BUF_W'(NBUF - 1) : wr_r - 1'b1;

  // record bytes go straight into the free buffer at the write pointer
  assign mem_we     = rx && !ovr_r && in_data;
  assign mem_waddr  = ADDR_W'(wr_r) * ADDR_W'(DATA_BYTES) + ADDR_W'(pos_r);
  assign mem_wdata  = byte_r;
  assign flag_we    = rx && last_r && frame_ok;
  assign flag_waddr = wr_r;
  assign flag_wdata = ((crc_new ^ CRC_INIT) == rcrc_new);

  always_comb begin
    crc_nxt     = crc_r;
    pos_nxt     = pos_r;
    ovr_nxt     = ovr_r;
    rcrc_nxt    = rcrc_r;
    wr_nxt      = wr_r;
    rd_nxt      = rd_r;
    cnt_nxt     = cnt_r;
    last_rx_nxt = last_rx_r;
    jq_enq      = proceed && is_rd;
    jq_buf      = rd_r;
    fill_cnt    = cnt_r;
    jq_job.need_read = 1'b0;
    jq_job.status    = STAT_OK;
    if (proceed) begin
      case (cmd_r)
        CMD_RX: begin
          crc_nxt  = crc_new;
          rcrc_nxt = rcrc_new;
          if (last_r) begin
            if (frame_ok) begin
              last_rx_nxt = now_r;
              wr_nxt      = wr_inc;
              if (cnt_r < CNT_W'(SLOTS)) begin
                cnt_nxt = cnt_r + 1'b1;
              end else begin
                // ring full: drop the oldest
                rd_nxt = rd_inc;
              end
            end
            crc_nxt  = CRC_INIT;
            pos_nxt  = '0;
            ovr_nxt  = 1'b0;
            rcrc_nxt = '0;
          end else if (pos_r == POS_MAX) begin
            ovr_nxt = 1'b1;
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
        end
        CMD_POP, CMD_PEEK: begin
          if (timed_out) begin
            jq_job.status = STAT_TIMEOUT;
          end else if (cnt_r == '0) begin
            jq_job.status = STAT_EMPTY;
          end else begin
            jq_job.need_read = 1'b1;
            if (cmd_r == CMD_POP) begin
              jq_buf   = rd_r;
              rd_nxt   = rd_inc;
              cnt_nxt  = cnt_r - 1'b1;
              fill_cnt = cnt_r - 1'b1;
            end else begin
              jq_buf = wr_dec;
            end
          end
        end
        default: begin
          // flush: the frame in progress keeps its buffer
          rd_nxt  = wr_r;
          cnt_nxt = '0;
        end
      endcase
    end
    fill_ext    = {4'h0, fill_cnt};
    jq_job.fill = fill_ext[3:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r  <= 1'b0;
      tmo_r     <= 32'd1000;
      crc_r     <= CRC_INIT;
      pos_r     <= '0;
      ovr_r     <= 1'b0;
      rcrc_r    <= '0;
      wr_r      <= '0;
      rd_r      <= '0;
      cnt_r     <= '0;
      last_rx_r <= '0;
    end else begin
      item_v_r  <= item_v_nxt;
      if (cfg_valid) begin
        tmo_r <= cfg_wdata;
      end
      crc_r     <= crc_nxt;
      pos_r     <= pos_nxt;
      ovr_r     <= ovr_nxt;
      rcrc_r    <= rcrc_nxt;
      wr_r      <= wr_nxt;
      rd_r      <= rd_nxt;
      cnt_r     <= cnt_nxt;
      last_rx_r <= last_rx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_push && !in_full) begin
      cmd_r  <= in_cmd;
      byte_r <= in_rx_byte;
      last_r <= in_rx_last;
      now_r  <= in_now_ms;
    end
  end

endmodule
`default_nettype wire

/* rtl/cprb_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cprb_back
// Holds the packet buffers and CRC verdicts, carries out read jobs and
// streams results through a two-entry output queue.
// ----------------------------------------------------------------------------
module cprb_back import cprb_pkg::*; #(
  parameter int SLOTS      = 8,
  parameter int DATA_BYTES = 32
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire logic                                          jq_empty,
  input  wire cprb_job_t                                     jq_job,
  input  wire logic [$clog2(SLOTS+1)-1:0]                    jq_buf,
  output logic                                               jq_deq,
  input  wire logic [$clog2(SLOTS+1)-1:0]                    query_buf,
  output logic                                               busy_hit,
  input  wire logic                                          mem_we,
  input  wire logic [$clog2((SLOTS+1)*DATA_BYTES)-1:0]       mem_waddr,
  input  wire logic [7:0]                                    mem_wdata,
  input  wire logic                                          flag_we,
  input  wire logic [$clog2(SLOTS+1)-1:0]                    flag_waddr,
  input  wire logic                                          flag_wdata,
  output logic                                               out_empty,
  input  wire logic                                          out_pop,
  output logic [7:0]                                         out_data_byte,
  output logic                                               out_last,
  output logic [1:0]                                         out_status,
  output logic [3:0]                                         out_fill_level
);

  localparam int NBUF   = SLOTS + 1;
  localparam int BUF_W  = $clog2(NBUF);
  localparam int DEPTH  = NBUF * DATA_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_FAIL   = 2'd2;
  localparam logic [1:0] S_STREAM = 2'd3;

  logic [7:0]        mem [DEPTH];
  logic              flag_mem [NBUF];

  logic [1:0]        state_r, state_nxt;
  logic [BUF_W-1:0]  buf_r;
  logic [3:0]        fill_r;
  logic [1:0]        status_r;
  logic              flag_q_r;
  logic [ADDR_W-1:0] addr_r;
  logic [IDX_W-1:0]  idx_r;
  logic [7:0]        mem_q_r;
  logic              pend_v_r;
  logic              pend_mem_r;
  cprb_res_t         pend_res_r;

  cprb_res_t         fifo_r [2];
  logic              wp_r, rp_r;
  logic [1:0]        cnt_r, cnt_nxt;
  logic [1:0]        occ;
  logic              pop_fire, room, rd_en, issue, last_idx;
  cprb_res_t         push_res, head;

  assign out_empty = (cnt_r == 2'd0);
  assign pop_fire  = out_pop && !out_empty;
  assign occ       = cnt_r + {1'b0, pend_v_r};
  assign room      = (occ < 2'd2) || pop_fire;
  assign last_idx  = (idx_r == IDX_W'(DATA_BYTES - 1));
  assign jq_deq    = (state_r == S_IDLE) && !jq_empty;
  assign rd_en     = (state_r == S_STREAM) && room;
  assign issue     = ((state_r == S_STREAM) || (state_r == S_FAIL)) && room;
  assign busy_hit  = (state_r != S_IDLE) && (buf_r == query_buf);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (!jq_empty) begin
          state_nxt = jq_job.need_read ? S_CHECK : S_FAIL;
        end
      end
      S_CHECK:  state_nxt = flag_q_r ? S_STREAM : S_FAIL;
      S_FAIL:   state_nxt = room ? S_IDLE : S_FAIL;
      S_STREAM: state_nxt = (room && last_idx) ? S_IDLE : S_STREAM;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    push_res = pend_res_r;
    if (pend_mem_r) begin
      push_res.data = mem_q_r;
    end
    head    = fifo_r[rp_r];
    cnt_nxt = cnt_r + {1'b0, pend_v_r} - {1'b0, pop_fire};
  end

  assign out_data_byte  = head.data;
  assign out_last       = head.last;
  assign out_status     = head.status;
  assign out_fill_level = head.fill;

  // buffers and verdicts
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      mem_q_r <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (flag_we) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
    if (jq_deq) begin
      flag_q_r <= flag_mem[jq_buf];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pend_v_r <= 1'b0;
      wp_r     <= 1'b0;
      rp_r     <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      state_r  <= state_nxt;
      pend_v_r <= issue;
      if (pend_v_r) begin
        wp_r <= ~wp_r;
      end
      if (pop_fire) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (jq_deq) begin
      buf_r    <= jq_buf;
      fill_r   <= jq_job.fill;
      status_r <= jq_job.status;
    end
    if ((state_r == S_CHECK) && !flag_q_r) begin
      status_r <= STAT_CRC;
    end
    if (state_r == S_CHECK) begin
      addr_r <= ADDR_W'(buf_r) * ADDR_W'(DATA_BYTES);
      idx_r  <= '0;
    end else if (rd_en) begin
      addr_r <= addr_r + 1'b1;
      idx_r  <= idx_r + 1'b1;
    end
    if (issue) begin
      pend_mem_r        <= (state_r == S_STREAM);
      pend_res_r.data   <= 8'h00;
      pend_res_r.last   <= (state_r == S_FAIL) || last_idx;
      pend_res_r.status <= (state_r == S_FAIL) ? status_r : STAT_OK;
      pend_res_r.fill   <= fill_r;
    end
    if (pend_v_r) begin
      fifo_r[wp_r] <= push_res;
    end
  end

endmodule
`default_nettype wire

/* rtl/crc_checked_packet_ring_buffer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc_checked_packet_ring_buffer_unit
// Overwriting ring of received packets with CRC-32 check, pop and peek.
// ----------------------------------------------------------------------------
// Requests enter through a push/full queue port and results leave through an
// empty/pop port. A receive byte or flush gives no result. A pop or peek
// becomes a read job. A timeout or empty-ring read passes the request
// register, job queue, fail state and pending result register; a CRC error
// also passes the check state. A good read streams DATA_BYTES results at one
// per cycle while the output queue has room, paced by the single read port of
// the packet memory. Up to two read jobs queue up while the front keeps taking
// requests; a receive byte waits while a queued or running read still uses the
// buffer being filled. The memory holds SLOTS+1 packet buffers of DATA_BYTES
// bytes; frames are written straight into the spare buffer, so a dropped frame
// never touches stored packets. No clearing pass is needed after reset.
// timeout_ms is written on the always-ready cfg port; the user must write it
// only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module crc_checked_packet_ring_buffer_unit import cprb_pkg::*; #(
  parameter int SLOTS      = 8,
  parameter int DATA_BYTES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        in_rx_last,
  input  wire logic [31:0] in_now_ms,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [7:0]       out_data_byte,
  output logic             out_last,
  output logic [1:0]       out_status,
  output logic [3:0]       out_fill_level,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_wdata
);

  localparam int BUF_W  = $clog2(SLOTS + 1);
  localparam int ADDR_W = $clog2((SLOTS + 1) * DATA_BYTES);

  logic              jq_full, jq_enq, jq_empty, jq_deq, jq_hit, back_hit;
  cprb_job_t         enq_job, head_job;
  logic [BUF_W-1:0]  enq_buf, head_buf, wr_buf;
  logic              mem_we, flag_we, flag_wdata;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [BUF_W-1:0]  flag_waddr;

  cprb_front #(
    .SLOTS      (SLOTS),
    .DATA_BYTES (DATA_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_cmd     (in_cmd),
    .in_rx_byte (in_rx_byte),
    .in_rx_last (in_rx_last),
    .in_now_ms  (in_now_ms),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_wdata  (cfg_wdata),
    .jq_full    (jq_full),
    .jq_enq     (jq_enq),
    .jq_job     (enq_job),
    .jq_buf     (enq_buf),
    .conflict   (jq_hit || back_hit),
    .wr_buf     (wr_buf),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .flag_we    (flag_we),
    .flag_waddr (flag_waddr),
    .flag_wdata (flag_wdata)
  );

  cprb_jobq #(
    .SLOTS (SLOTS)
  ) u_jobq (
    .clk       (clk),
    .rst_n     (rst_n),
    .enq       (jq_enq),
    .enq_job   (enq_job),
    .enq_buf   (enq_buf),
    .full      (jq_full),
    .deq       (jq_deq),
    .empty     (jq_empty),
    .head_job  (head_job),
    .head_buf  (head_buf),
    .query_buf (wr_buf),
    .hit       (jq_hit)
  );

  cprb_back #(
    .SLOTS      (SLOTS),
    .DATA_BYTES (DATA_BYTES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .jq_empty       (jq_empty),
    .jq_job         (head_job),
    .jq_buf         (head_buf),
    .jq_deq         (jq_deq),
    .query_buf      (wr_buf),
    .busy_hit       (back_hit),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .flag_we        (flag_we),
    .flag_waddr     (flag_waddr),
    .flag_wdata     (flag_wdata),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_data_byte  (out_data_byte),
    .out_last       (out_last),
    .out_status     (out_status),
    .out_fill_level (out_fill_level)
  );

endmodule
`default_nettype wire

/* tb/crc_checked_packet_ring_buffer_unit_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_checked_packet_ring_buffer_unit_checker
// Watches the request, result and cfg channels of the packet ring buffer,
// keeps its own copy of the ring, the frame in progress and timeout_ms, and
// compares every popped result field by field against the oldest prediction.
// ----------------------------------------------------------------------------

package crc_ring_tb_pkg;

  // bit-serial reflected CRC-32 step over one byte, lsb first
  function automatic logic [31:0] crc32_update(input logic [31:0] acc,
                                               input logic [7:0] octet);
    logic [31:0] r;
    bit          fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ octet[i];
      r  = r >> 1;
      if (fb) r = r ^ cprb_pkg::CRC_POLY;
    end
    return r;
  endfunction

endpackage

module crc_checked_packet_ring_buffer_unit_checker
  import cprb_pkg::*;
  import crc_ring_tb_pkg::*;
#(
  parameter int SLOTS      = 8,
  parameter int DATA_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_rx_last,
  input  logic [31:0] in_now_ms,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [7:0]  out_data_byte,
  input  logic        out_last,
  input  logic [1:0]  out_status,
  input  logic [3:0]  out_fill_level,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_wdata,
  output int          mismatch_count,
  output int          results_waiting
);

  localparam int          FRAME_BYTES   = DATA_BYTES + 4;
  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

  logic [7:0]  slot_mem [SLOTS*DATA_BYTES];
  bit          slot_good [SLOTS];
  logic [7:0]  frame_buf [DATA_BYTES];
  logic [31:0] crc_acc;
  logic [31:0] crc_rcvd;
  logic [31:0] last_rx_ms;
  logic [31:0] timeout_ms;
  int unsigned frame_pos;
  int unsigned wr_ptr;
  int unsigned rd_ptr;
  int unsigned held;
  bit          frame_over;
  cprb_res_t   expected_bytes [$];
  int          errors = 0;

  function automatic void expect_result(input logic [7:0] d, input logic l,
                                        input logic [1:0] s);
    cprb_res_t r;
    r.data   = d;
    r.last   = l;
    r.status = s;
    r.fill   = held[3:0];
    expected_bytes.push_back(r);
  endfunction

  function automatic void restart_frame();
    crc_acc    = CRC_INIT;
    crc_rcvd   = '0;
    frame_pos  = 0;
    frame_over = 1'b0;
  endfunction

  function automatic void take_byte(input logic [7:0] b, input logic fin,
                                    input logic [31:0] now);
    int unsigned pos;
    int unsigned ws;
    pos = frame_pos;
    if (!frame_over) begin
      if (pos < DATA_BYTES) begin
        frame_buf[pos] = b;
        crc_acc = crc32_update(crc_acc, b);
      end else if (pos < FRAME_BYTES) begin
        crc_rcvd = crc_rcvd | ({24'h0, b} << (8 * (pos - DATA_BYTES)));
      end
    end
    if (fin) begin
      if (!frame_over && pos + 1 == FRAME_BYTES) begin
        ws = wr_ptr;
        for (int i = 0; i < DATA_BYTES; i++) slot_mem[ws*DATA_BYTES + i] = frame_buf[i];
        slot_good[ws] = (~crc_acc == crc_rcvd);
        last_rx_ms = now;
        wr_ptr = (ws + 1) % SLOTS;
        // full ring: overwrite the oldest packet
        if (held < SLOTS) held++;
        else rd_ptr = (rd_ptr + 1) % SLOTS;
      end
      restart_frame();
    end else if (pos >= POS_MAX) begin
      frame_over = 1'b1;
    end else begin
      frame_pos = pos + 1;
    end
  endfunction

  function automatic void read_packet(input logic [1:0] cmd, input logic [31:0] now);
    int unsigned slot;
    logic [31:0] age;
    age = now - last_rx_ms;
    if (age > timeout_ms) begin
      expect_result(8'h00, 1'b1, STAT_TIMEOUT);
      return;
    end
    if (held == 0) begin
      expect_result(8'h00, 1'b1, STAT_EMPTY);
      return;
    end
    if (cmd == CMD_POP) begin
      slot   = rd_ptr;
      rd_ptr = (slot + 1) % SLOTS;
      held--;
    end else begin
      slot = (wr_ptr + SLOTS - 1) % SLOTS;
    end
    // a bad pop still removes the packet
    if (!slot_good[slot]) begin
      expect_result(8'h00, 1'b1, STAT_CRC);
      return;
    end
    for (int k = 0; k < DATA_BYTES; k++)
      expect_result(slot_mem[slot*DATA_BYTES + k], k == DATA_BYTES - 1, STAT_OK);
  endfunction

  function automatic void ring_apply(input logic [1:0] cmd, input logic [7:0] b,
                                     input logic fin, input logic [31:0] now);
    case (cmd)
      CMD_RX: begin
        take_byte(b, fin, now);
      end
      CMD_FLUSH: begin
        wr_ptr = 0;
        rd_ptr = 0;
        held   = 0;
      end
      default: begin
        read_packet(cmd, now);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    cprb_res_t want;
    if (!rst_n) begin
      timeout_ms = TIMEOUT_RESET;
      restart_frame();
      wr_ptr     = 0;
      rd_ptr     = 0;
      held       = 0;
      last_rx_ms = '0;
      expected_bytes.delete();
    end else begin
      if (cfg_valid && cfg_ready) timeout_ms = cfg_wdata;
      if (in_push && !in_full) ring_apply(in_cmd, in_rx_byte, in_rx_last, in_now_ms);
      if (out_pop && !out_empty) begin
        if (expected_bytes.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result: data %02h last %0b status %0d fill %0d",
                     $time, out_data_byte, out_last, out_status, out_fill_level);
        end else begin
          want = expected_bytes.pop_front();
          if (want.data !== out_data_byte || want.last !== out_last ||
              want.status !== out_status || want.fill !== out_fill_level) begin
            errors++;
            if (errors <= 10)
              $display({"%0t: result differs: expected data %02h last %0b status %0d",
                        " fill %0d, got data %02h last %0b status %0d fill %0d"},
                       $time, want.data, want.last, want.status, want.fill,
                       out_data_byte, out_last, out_status, out_fill_level);
          end
        end
      end
    end
    mismatch_count  <= errors;
    results_waiting <= expected_bytes.size();
  end

endmodule

/* tb/crc_checked_packet_ring_buffer_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_checked_packet_ring_buffer_unit_test
// Drives frames, pops, peeks and flushes into the packet ring buffer in
// bursts, stalls the result side on a changing pattern, sweeps timeout_ms
// across phases and reports the checker's verdict.
// ----------------------------------------------------------------------------

module crc_checked_packet_ring_buffer_unit_test;
  import cprb_pkg::*;
  import crc_ring_tb_pkg::*;

  localparam int SLOTS         = 8;
  localparam int DATA_BYTES    = 32;
  localparam int FRAME_MAX     = 72;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 24;

  typedef enum {FRAME_GOOD, FRAME_BAD_CRC, FRAME_SHORT, FRAME_LONG, FRAME_OVERRUN} frame_kind_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [1:0]  in_cmd;
  logic [7:0]  in_rx_byte;
  logic        in_rx_last;
  logic [31:0] in_now_ms;
  logic        out_empty;
  logic        out_pop;
  logic [7:0]  out_data_byte;
  logic        out_last;
  logic [1:0]  out_status;
  logic [3:0]  out_fill_level;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_wdata;

  int          mismatch_count;
  int          results_waiting;
  logic [31:0] clock_ms;
  int          ms_step_max;
  int          burst_left;
  int          items_sent;
  int          good_frames;
  int          pop_mode;
  int          pop_mode_left;
  int          pop_stall_left;
  int          pop_tick;
  int          cycle_count;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  crc_checked_packet_ring_buffer_unit #(
    .SLOTS      (SLOTS),
    .DATA_BYTES (DATA_BYTES)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_cmd         (in_cmd),
    .in_rx_byte     (in_rx_byte),
    .in_rx_last     (in_rx_last),
    .in_now_ms      (in_now_ms),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_data_byte  (out_data_byte),
    .out_last       (out_last),
    .out_status     (out_status),
    .out_fill_level (out_fill_level),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_wdata      (cfg_wdata)
  );

  crc_checked_packet_ring_buffer_unit_checker #(
    .SLOTS      (SLOTS),
    .DATA_BYTES (DATA_BYTES)
  ) ring_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_cmd          (in_cmd),
    .in_rx_byte      (in_rx_byte),
    .in_rx_last      (in_rx_last),
    .in_now_ms       (in_now_ms),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_data_byte   (out_data_byte),
    .out_last        (out_last),
    .out_status      (out_status),
    .out_fill_level  (out_fill_level),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .results_waiting (results_waiting)
  );

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_req(input logic [1:0] cmd, input logic [7:0] b, input logic fin);
    if (burst_left == 0) begin
      in_push = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 48);
    end
    in_cmd     = cmd;
    in_rx_byte = b;
    in_rx_last = fin;
    in_now_ms  = clock_ms;
    in_push    = 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    @(negedge clk);
    burst_left--;
    items_sent++;
    if (ms_step_max > 0) clock_ms = clock_ms + $urandom_range(0, ms_step_max);
  endtask

  task automatic send_frame(input frame_kind_t kind);
    logic [7:0]  fb [FRAME_MAX];
    logic [31:0] acc;
    int          len;
    int          pattern;
    pattern = $urandom_range(0, 7);
    for (int i = 0; i < FRAME_MAX; i++)
      fb[i] = (pattern == 0) ? 8'h00 : (pattern == 1) ? 8'hFF : 8'($urandom);
    acc = CRC_INIT;
    for (int i = 0; i < DATA_BYTES; i++) acc = crc32_update(acc, fb[i]);
    acc = ~acc;
    for (int i = 0; i < 4; i++) fb[DATA_BYTES + i] = acc[8*i +: 8];
    len = DATA_BYTES + 4;
    case (kind)
      FRAME_BAD_CRC: fb[$urandom_range(0, DATA_BYTES + 3)] ^= 8'(1 << $urandom_range(0, 7));
      FRAME_SHORT:   len = $urandom_range(1, DATA_BYTES + 3);
      FRAME_LONG:    len = $urandom_range(DATA_BYTES + 5, 64);
      FRAME_OVERRUN: len = $urandom_range(65, FRAME_MAX);
      default:       len = DATA_BYTES + 4;
    endcase
    for (int i = 0; i < len; i++) begin
      // slip a read in between frame bytes now and then
      if ($urandom_range(0, 39) == 0)
        send_req($urandom_range(0, 1) ? CMD_POP : CMD_PEEK, 8'($urandom), 1'($urandom));
      send_req(CMD_RX, fb[i], i == len - 1);
    end
    if (kind == FRAME_GOOD) good_frames++;
  endtask

  // hold requests until every predicted result has been popped
  task automatic settle_all();
    in_push = 1'b0;
    while (results_waiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_timeout(input logic [31:0] value);
    cfg_wdata = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_phase(input logic [31:0] tmo, input bit write_it, input int step);
    int goods_at_start;
    int items_at_start;
    int pick;
    if (write_it) write_timeout(tmo);
    ms_step_max    = step;
    goods_at_start = good_frames;
    items_at_start = items_sent;
    while (good_frames - goods_at_start < 1 || items_sent - items_at_start < PHASE_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 48)      send_frame(FRAME_GOOD);
      else if (pick < 55) send_frame(FRAME_BAD_CRC);
      else if (pick < 58) send_frame(FRAME_SHORT);
      else if (pick < 60) send_frame(FRAME_LONG);
      else if (pick < 62) send_frame(FRAME_OVERRUN);
      else if (pick < 74) repeat ($urandom_range(1, 3))
                            send_req(CMD_POP, 8'($urandom), 1'($urandom));
      else if (pick < 84) send_req(CMD_PEEK, 8'($urandom), 1'($urandom));
      else if (pick < 86) send_req(CMD_FLUSH, 8'($urandom), 1'($urandom));
      else if (pick < 92) send_req(2'($urandom), 8'($urandom), 1'($urandom));
      else if (pick < 95) clock_ms = clock_ms + $urandom;
      else if (pick < 97) settle_all();
      else                clock_ms = clock_ms + $urandom_range(0, 2000);
    end
    settle_all();
  endtask

  // result side: switch between stall patterns every so often
  initial begin
    out_pop        = 1'b0;
    pop_mode       = 0;
    pop_mode_left  = 0;
    pop_stall_left = 0;
    pop_tick       = 0;
    forever begin
      @(negedge clk);
      if (pop_mode_left == 0) begin
        pop_mode      = $urandom_range(0, 3);
        pop_mode_left = $urandom_range(20, 150);
      end
      pop_mode_left--;
      case (pop_mode)
        0: out_pop = 1'b1;
        1: out_pop = 1'($urandom);
        2: begin
          pop_tick = (pop_tick + 1) % 3;
          out_pop  = (pop_tick == 0);
        end
        default: begin
          if (pop_stall_left > 0) begin
            pop_stall_left--;
            out_pop = 1'b0;
          end else begin
            out_pop = 1'b1;
            if ($urandom_range(0, 7) == 0) pop_stall_left = $urandom_range(1, 10);
          end
        end
      endcase
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("crc_checked_packet_ring_buffer_unit: mismatch");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    in_push     = 1'b0;
    in_cmd      = CMD_RX;
    in_rx_byte  = 8'h00;
    in_rx_last  = 1'b0;
    in_now_ms   = '0;
    cfg_valid   = 1'b0;
    cfg_wdata   = '0;
    clock_ms    = '0;
    ms_step_max = 0;
    burst_left  = 0;
    items_sent  = 0;
    good_frames = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty ring, timeout boundary, time wrap, flush and a one-byte frame
    send_req(CMD_POP, 8'hFF, 1'b1);
    send_req(CMD_PEEK, 8'h00, 1'b0);
    clock_ms = 32'd1000;
    send_req(CMD_POP, 8'h5A, 1'b0);
    clock_ms = 32'd1001;
    send_req(CMD_PEEK, 8'hA5, 1'b1);
    clock_ms = 32'hFFFF_FFFF;
    send_req(CMD_POP, 8'h00, 1'b0);
    send_req(CMD_FLUSH, 8'hFF, 1'b1);
    clock_ms = 32'd5;
    send_req(CMD_RX, 8'hA5, 1'b1);
    send_req(CMD_POP, 8'h00, 1'b0);
    send_req(CMD_PEEK, 8'h00, 1'b0);
    settle_all();

    run_phase(32'd1000, 1'b0, 3);
    run_phase(32'hFFFF_FFFF, 1'b1, 40);
    run_phase(32'd0, 1'b1, 0);
    run_phase($urandom_range(50, 600), 1'b1, 4);
    run_phase(32'd1000, 1'b1, 3);
    settle_all();

    if (mismatch_count == 0 && results_waiting == 0) begin
      $display("crc_checked_packet_ring_buffer_unit: match");
    end else begin
      $display("crc_checked_packet_ring_buffer_unit: mismatch");
    end
    $finish;
  end

endmodule
